// ----- hdl/qdp_pkg.sv -----
package qdp_pkg;

    // Parser modes
    typedef enum logic [3:0] {
        MODE_WAIT    = 4'd0,
        MODE_COMMENT = 4'd1,
        MODE_PC      = 4'd2,
        MODE_PN      = 4'd3,
        MODE_PF      = 4'd4,
        MODE_VSTART  = 4'd5,
        MODE_VNUM    = 4'd6,
        MODE_GAP     = 4'd7,
        MODE_CNUM    = 4'd8,
        MODE_CLAUSE  = 4'd9,
        MODE_SCOPE   = 4'd10,
        MODE_NEG     = 4'd11,
        MODE_LIT     = 4'd12,
        MODE_HALT    = 4'd13
    } mode_t;

    // Event kinds
    typedef enum logic [2:0] {
        EV_VARS    = 3'd0,
        EV_CLAUSES = 3'd1,
        EV_FORALL  = 3'd2,
        EV_EXISTS  = 3'd3,
        EV_LIT     = 3'd4,
        EV_DONE    = 3'd5,
        EV_ERR     = 3'd6
    } ev_kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_PREAMBLE = 3'd1,
        ERR_BAD_PREAMBLE = 3'd2,
        ERR_NEED_DIG_MIN = 3'd3,
        ERR_NEED_DIG    = 3'd4,
        ERR_EMPTY       = 3'd5,
        ERR_OVERFLOW    = 3'd6
    } err_code_t;

    // Characters
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam int VALUE_W = 32;

    // One parse event
    typedef struct packed {
        ev_kind_t             kind;
        logic [VALUE_W-1:0]   value;
        err_code_t            code;
    } event_t;

    // What one input item produces
    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } step_out_t;

endpackage

// ----- hdl/qdp_step.sv -----
module qdp_step #(
    parameter int NUMBER_BITS = 32
) (
    input  qdp_pkg::mode_t           mode,
    input  logic [NUMBER_BITS-2:0]   acc,
    input  logic                     neg,
    input  logic                     seen,
    input  logic [7:0]               char_code,
    input  logic                     end_of_input,
    output qdp_pkg::mode_t           mode_next,
    output logic [NUMBER_BITS-2:0]   acc_next,
    output logic                     neg_next,
    output logic                     seen_next,
    output qdp_pkg::step_out_t       result
);

    localparam int PW = NUMBER_BITS + 3;
    localparam logic [PW-1:0] LIMIT = (PW'(1) << (NUMBER_BITS - 1)) - PW'(1);

    logic                      is_ws;
    logic                      is_dig;
    logic [3:0]                dval;
    logic [PW-1:0]             prod;
    logic                      ovf;
    logic [qdp_pkg::VALUE_W-1:0] acc_ext;
    logic [qdp_pkg::VALUE_W-1:0] lit_val;
    logic [7:0]                want;

    // clause-section handling of the current byte
    logic                      allow_scope;
    logic                      cl_emit;
    qdp_pkg::event_t           cl_ev;
    qdp_pkg::mode_t            cl_mode;
    logic                      cl_load;
    logic                      cl_neg;

    qdp_pkg::event_t           ev_none;
    qdp_pkg::event_t           ev_num;

    // Classify the byte and grow the accumulator by one digit
    always_comb
    begin
        is_ws   = (char_code == qdp_pkg::CH_SPACE) ||
                  (char_code >= qdp_pkg::CH_TAB && char_code <= qdp_pkg::CH_CR);
        is_dig  = (char_code >= qdp_pkg::CH_ZERO) && (char_code <= qdp_pkg::CH_NINE);
        dval    = char_code[3:0];
        prod    = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(dval);
        ovf     = prod > LIMIT;
        acc_ext = qdp_pkg::VALUE_W'(acc);
        lit_val = neg ? (~acc_ext + qdp_pkg::VALUE_W'(1)) : acc_ext;
        want    = (mode == qdp_pkg::MODE_PC) ? qdp_pkg::CH_C :
                  ((mode == qdp_pkg::MODE_PN) ? qdp_pkg::CH_N : qdp_pkg::CH_F);
        ev_none = '{kind: qdp_pkg::EV_VARS, value: '0, code: qdp_pkg::ERR_NONE};
    end

    // Decide what a byte does in the clause section
    always_comb
    begin
        allow_scope = (mode != qdp_pkg::MODE_SCOPE);
        cl_emit     = 1'b0;
        cl_ev       = ev_none;
        cl_mode     = allow_scope ? qdp_pkg::MODE_CLAUSE : qdp_pkg::MODE_SCOPE;
        cl_load     = 1'b0;
        cl_neg      = neg;
        if (is_ws)
        begin
            cl_emit = 1'b0;
        end
        else if (allow_scope && (char_code == qdp_pkg::CH_A || char_code == qdp_pkg::CH_E))
        begin
            cl_emit    = 1'b1;
            cl_ev.kind = (char_code == qdp_pkg::CH_A) ? qdp_pkg::EV_FORALL
                                                      : qdp_pkg::EV_EXISTS;
            cl_mode    = qdp_pkg::MODE_SCOPE;
        end
        else if (is_dig)
        begin
            cl_neg  = 1'b0;
            cl_load = 1'b1;
            cl_mode = qdp_pkg::MODE_LIT;
        end
        else if (char_code == qdp_pkg::CH_MINUS)
        begin
            cl_neg  = 1'b1;
            cl_mode = qdp_pkg::MODE_NEG;
        end
        else
        begin
            cl_emit    = 1'b1;
            cl_ev.kind = qdp_pkg::EV_ERR;
            cl_ev.code = qdp_pkg::ERR_NEED_DIG_MIN;
            cl_mode    = qdp_pkg::MODE_HALT;
        end
    end

    // Next state and events
    always_comb
    begin
        mode_next = mode;
        acc_next  = acc;
        neg_next  = neg;
        seen_next = seen;
        result    = '{count: 2'd0, ev0: ev_none, ev1: ev_none};
        ev_num    = ev_none;

        if (mode == qdp_pkg::MODE_HALT)
        begin
            mode_next = qdp_pkg::MODE_HALT;
        end
        else if (end_of_input)
        begin
            mode_next        = qdp_pkg::MODE_HALT;
            result.count     = 2'd1;
            result.ev0.kind  = qdp_pkg::EV_ERR;
            unique case (mode)
                qdp_pkg::MODE_WAIT:
                    result.ev0.code = seen ? qdp_pkg::ERR_NO_PREAMBLE : qdp_pkg::ERR_EMPTY;
                qdp_pkg::MODE_COMMENT:
                    result.ev0.code = qdp_pkg::ERR_NO_PREAMBLE;
                qdp_pkg::MODE_VNUM:
                begin
                    result.count     = 2'd2;
                    result.ev0       = ev_none;
                    result.ev0.kind  = qdp_pkg::EV_VARS;
                    result.ev0.value = acc_ext;
                    result.ev1.kind  = qdp_pkg::EV_ERR;
                    result.ev1.code  = qdp_pkg::ERR_BAD_PREAMBLE;
                end
                qdp_pkg::MODE_CNUM, qdp_pkg::MODE_LIT:
                begin
                    result.count     = 2'd2;
                    result.ev0       = ev_none;
                    result.ev0.kind  = (mode == qdp_pkg::MODE_CNUM) ? qdp_pkg::EV_CLAUSES
                                                                   : qdp_pkg::EV_LIT;
                    result.ev0.value = (mode == qdp_pkg::MODE_CNUM) ? acc_ext : lit_val;
                    result.ev1.kind  = qdp_pkg::EV_DONE;
                end
                qdp_pkg::MODE_NEG:
                    result.ev0.code = qdp_pkg::ERR_NEED_DIG;
                qdp_pkg::MODE_CLAUSE, qdp_pkg::MODE_SCOPE:
                    result.ev0.kind = qdp_pkg::EV_DONE;
                default:
                    result.ev0.code = qdp_pkg::ERR_BAD_PREAMBLE;
            endcase
        end
        else
        begin
            seen_next = 1'b1;
            unique case (mode)
                qdp_pkg::MODE_WAIT:
                begin
                    if (!is_ws)
                    begin
                        if (char_code == qdp_pkg::CH_C)
                            mode_next = qdp_pkg::MODE_COMMENT;
                        else if (char_code == qdp_pkg::CH_P)
                            mode_next = qdp_pkg::MODE_PC;
                        else
                        begin
                            mode_next       = qdp_pkg::MODE_HALT;
                            result.count    = 2'd1;
                            result.ev0.kind = qdp_pkg::EV_ERR;
                            result.ev0.code = qdp_pkg::ERR_NO_PREAMBLE;
                        end
                    end
                end
                qdp_pkg::MODE_COMMENT:
                begin
                    if (char_code == qdp_pkg::CH_LF)
                        mode_next = qdp_pkg::MODE_WAIT;
                end
                qdp_pkg::MODE_PC, qdp_pkg::MODE_PN, qdp_pkg::MODE_PF:
                begin
                    if (!is_ws)
                    begin
                        if (char_code == want)
                            mode_next = qdp_pkg::mode_t'(mode + 4'd1);
                        else
                        begin
                            mode_next       = qdp_pkg::MODE_HALT;
                            result.count    = 2'd1;
                            result.ev0.kind = qdp_pkg::EV_ERR;
                            result.ev0.code = qdp_pkg::ERR_BAD_PREAMBLE;
                        end
                    end
                end
                qdp_pkg::MODE_VSTART, qdp_pkg::MODE_GAP:
                begin
                    if (!is_ws)
                    begin
                        if (is_dig)
                        begin
                            acc_next  = (NUMBER_BITS-1)'(dval);
                            mode_next = (mode == qdp_pkg::MODE_VSTART) ? qdp_pkg::MODE_VNUM
                                                                       : qdp_pkg::MODE_CNUM;
                        end
                        else
                        begin
                            mode_next       = qdp_pkg::MODE_HALT;
                            result.count    = 2'd1;
                            result.ev0.kind = qdp_pkg::EV_ERR;
                            result.ev0.code = qdp_pkg::ERR_BAD_PREAMBLE;
                        end
                    end
                end
                qdp_pkg::MODE_VNUM, qdp_pkg::MODE_CNUM, qdp_pkg::MODE_LIT:
                begin
                    if (is_dig)
                    begin
                        if (ovf)
                        begin
                            mode_next       = qdp_pkg::MODE_HALT;
                            result.count    = 2'd1;
                            result.ev0.kind = qdp_pkg::EV_ERR;
                            result.ev0.code = qdp_pkg::ERR_OVERFLOW;
                        end
                        else
                            acc_next = prod[NUMBER_BITS-2:0];
                    end
                    else
                    begin
                        ev_num.kind  = (mode == qdp_pkg::MODE_VNUM) ? qdp_pkg::EV_VARS :
                                       ((mode == qdp_pkg::MODE_CNUM) ? qdp_pkg::EV_CLAUSES
                                                                    : qdp_pkg::EV_LIT);
                        ev_num.value = (mode == qdp_pkg::MODE_LIT) ? lit_val : acc_ext;
                        result.ev0   = ev_num;
                        if (mode == qdp_pkg::MODE_VNUM)
                        begin
                            if (is_ws)
                            begin
                                mode_next    = qdp_pkg::MODE_GAP;
                                result.count = 2'd1;
                            end
                            else
                            begin
                                mode_next       = qdp_pkg::MODE_HALT;
                                result.count    = 2'd2;
                                result.ev1.kind = qdp_pkg::EV_ERR;
                                result.ev1.code = qdp_pkg::ERR_BAD_PREAMBLE;
                            end
                        end
                        else
                        begin
                            // the ending byte then starts the clause section
                            result.count = cl_emit ? 2'd2 : 2'd1;
                            result.ev1   = cl_ev;
                            mode_next    = cl_mode;
                            neg_next     = cl_neg;
                            if (cl_load)
                                acc_next = (NUMBER_BITS-1)'(dval);
                        end
                    end
                end
                qdp_pkg::MODE_CLAUSE, qdp_pkg::MODE_SCOPE:
                begin
                    result.count = cl_emit ? 2'd1 : 2'd0;
                    result.ev0   = cl_ev;
                    mode_next    = cl_mode;
                    neg_next     = cl_neg;
                    if (cl_load)
                        acc_next = (NUMBER_BITS-1)'(dval);
                end
                qdp_pkg::MODE_NEG:
                begin
                    if (is_dig)
                    begin
                        acc_next  = (NUMBER_BITS-1)'(dval);
                        mode_next = qdp_pkg::MODE_LIT;
                    end
                    else
                    begin
                        mode_next       = qdp_pkg::MODE_HALT;
                        result.count    = 2'd1;
                        result.ev0.kind = qdp_pkg::EV_ERR;
                        result.ev0.code = qdp_pkg::ERR_NEED_DIG;
                    end
                end
                default:
                    mode_next = qdp_pkg::MODE_HALT;
            endcase
        end
    end

endmodule

// ----- hdl/qdimacs_char_parser.sv -----
// Channel  Dir  tdata (low bit up)                          tuser          tlast
// s_axis   in   char_code[7:0]                              end_of_input   -
// m_axis   out  event_value[31:0], error_code[34:32], pad   event_kind     last_of_run
//
// Each item passes an input register, then combinational parse logic that writes
// up to two events into a four-entry result queue; one item per cycle while the
// queue has room. An item's first event reaches m_axis from the queue register.
// Two events per item drain at one per cycle, so long runs of them stall s_axis
// once the queue holds three or more entries. rst_n (async, low) returns the
// parser to the wait-for-preamble mode; after done or error, items are dropped.
module qdimacs_char_parser #(
    parameter int NUMBER_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tuser,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // event_value[31:0], error_code[34:32]
    output logic [2:0]  m_axis_tuser,   // event_kind
    output logic        m_axis_tlast    // last_of_run
);

    typedef struct packed {
        qdp_pkg::event_t ev;
        logic            last;
    } qentry_t;

    logic                    stage_valid_reg;
    logic [7:0]              stage_char_reg;
    logic                    stage_eof_reg;

    qdp_pkg::mode_t          mode_reg, mode_next;
    logic [NUMBER_BITS-2:0]  acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic                    seen_reg, seen_next;
    qdp_pkg::step_out_t      step_res;

    qentry_t                 queue_reg [4];
    logic [1:0]              wr_ptr_reg, wr_ptr_next;
    logic [1:0]              rd_ptr_reg, rd_ptr_next;
    logic [2:0]              count_reg, count_next;

    logic                    room;
    logic                    proc;
    logic                    pop;
    logic [1:0]              push_n;

    assign room          = (count_reg <= 3'd2);
    assign proc          = stage_valid_reg && room;
    assign s_axis_tready = !stage_valid_reg || room;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_n        = proc ? step_res.count : 2'd0;

    qdp_step #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_step (
        .mode         (mode_reg),
        .acc          (acc_reg),
        .neg          (neg_reg),
        .seen         (seen_reg),
        .char_code    (stage_char_reg),
        .end_of_input (stage_eof_reg),
        .mode_next    (mode_next),
        .acc_next     (acc_next),
        .neg_next     (neg_next),
        .seen_next    (seen_next),
        .result       (step_res)
    );

    // Hold the accepted item in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (s_axis_tready)
            stage_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            stage_char_reg <= s_axis_tdata;
            stage_eof_reg  <= s_axis_tuser;
        end
    end

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= qdp_pkg::MODE_WAIT;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end
        else if (proc)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            seen_reg <= seen_next;
        end
    end

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the events of one item
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= '{ev: step_res.ev0, last: (push_n == 2'd1)};
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= '{ev: step_res.ev1, last: 1'b1};
    end

    // Present the head event
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_axis_tdata  = {5'b00000, queue_reg[rd_ptr_reg].ev.code,
                            queue_reg[rd_ptr_reg].ev.value};
    assign m_axis_tuser  = queue_reg[rd_ptr_reg].ev.kind;
    assign m_axis_tlast  = queue_reg[rd_ptr_reg].last;

endmodule

// ----- hdl/qdp_checker.sv -----
module qdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic finished_reg;

    // Track delivery of a done or error event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            finished_reg <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready &&
                 (m_axis_tuser == qdp_pkg::EV_DONE || m_axis_tuser == qdp_pkg::EV_ERR))
            finished_reg <= 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == qdp_pkg::EV_DONE || m_axis_tuser == qdp_pkg::EV_ERR)
        |-> m_axis_tlast)
        else $error("done or error event not last of its run");

    a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != qdp_pkg::EV_ERR |-> m_axis_tdata[34:32] == 3'd0)
        else $error("error code on a non-error event");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == qdp_pkg::EV_ERR
        |-> m_axis_tdata[34:32] != 3'd0 && m_axis_tdata[31:0] == 32'd0)
        else $error("malformed error event");

    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !m_axis_tvalid)
        else $error("event after done or error");

endmodule

bind qdimacs_char_parser qdp_checker u_qdp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/qdimacs_event_checker.sv -----
`timescale 1ns / 1ps

module qdimacs_event_checker
    import qdp_pkg::*;
#(
    parameter int NUMBER_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tuser,   // end_of_input
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // event_value[31:0], error_code[34:32]
    input  logic [2:0]  m_axis_tuser,   // event_kind
    input  logic        m_axis_tlast,   // last_of_run
    output int          mismatch_count,
    output int          events_pending,
    output int          events_checked,
    output int          chars_seen
);

    localparam logic [63:0] MAGNITUDE_MAX = (64'd1 << (NUMBER_BITS - 1)) - 64'd1;

    typedef struct packed {
        ev_kind_t    kind;
        logic [31:0] value;
        err_code_t   code;
        logic        last;
    } parse_event_t;

    // Shadow copy of the parser state
    mode_t        mode_q;
    logic [30:0]  magnitude_q;
    logic         negative_q;
    logic         seen_any_q;

    parse_event_t awaited_events[$];
    int           mismatches;
    int           checked;
    int           chars;

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic logic [31:0] literal_now();
        return negative_q ? -{1'b0, magnitude_q} : {1'b0, magnitude_q};
    endfunction

    task automatic post_event(input ev_kind_t kind, input logic [31:0] value,
                              input err_code_t code);
        parse_event_t ev;
        ev.kind  = kind;
        ev.value = value;
        ev.code  = code;
        ev.last  = 1'b0;
        awaited_events.push_back(ev);
    endtask

    task automatic abort_parse(input err_code_t code);
        post_event(EV_ERR, '0, code);
        mode_q = MODE_HALT;
    endtask

    // Grow the number by one digit; flag overflow past the signed range
    task automatic accumulate_digit(input logic [7:0] ch);
        logic [63:0] grown;
        grown = {33'd0, magnitude_q} * 64'd10 + {56'd0, ch - CH_ZERO};
        if (grown > MAGNITUDE_MAX)
            abort_parse(ERR_OVERFLOW);
        else
            magnitude_q = grown[30:0];
    endtask

    task automatic start_number(input logic [7:0] ch, input mode_t next_mode);
        magnitude_q = {23'd0, ch - CH_ZERO};
        mode_q      = next_mode;
    endtask

    // One byte in the clause section; scope letters only where allowed
    task automatic clause_byte(input logic [7:0] ch, input logic scope_ok);
        if (!is_space(ch))
        begin
            if (scope_ok && ch == CH_A)
            begin
                post_event(EV_FORALL, '0, ERR_NONE);
                mode_q = MODE_SCOPE;
            end
            else if (scope_ok && ch == CH_E)
            begin
                post_event(EV_EXISTS, '0, ERR_NONE);
                mode_q = MODE_SCOPE;
            end
            else if (is_digit(ch))
            begin
                negative_q = 1'b0;
                start_number(ch, MODE_LIT);
            end
            else if (ch == CH_MINUS)
            begin
                negative_q = 1'b1;
                mode_q     = MODE_NEG;
            end
            else
                abort_parse(ERR_NEED_DIG_MIN);
        end
    endtask

    // Work out the events that one accepted item causes
    task automatic predict_item(input logic [7:0] ch, input logic eof);
        int           count_before;
        parse_event_t tail;
        count_before = awaited_events.size();
        if (mode_q != MODE_HALT)
        begin
            if (eof)
            begin
                case (mode_q)
                    MODE_WAIT:
                        if (seen_any_q)
                            abort_parse(ERR_NO_PREAMBLE);
                        else
                            abort_parse(ERR_EMPTY);
                    MODE_COMMENT:
                        abort_parse(ERR_NO_PREAMBLE);
                    MODE_VNUM:
                    begin
                        post_event(EV_VARS, {1'b0, magnitude_q}, ERR_NONE);
                        abort_parse(ERR_BAD_PREAMBLE);
                    end
                    MODE_CNUM:
                    begin
                        post_event(EV_CLAUSES, {1'b0, magnitude_q}, ERR_NONE);
                        post_event(EV_DONE, '0, ERR_NONE);
                    end
                    MODE_LIT:
                    begin
                        post_event(EV_LIT, literal_now(), ERR_NONE);
                        post_event(EV_DONE, '0, ERR_NONE);
                    end
                    MODE_NEG:
                        abort_parse(ERR_NEED_DIG);
                    MODE_CLAUSE, MODE_SCOPE:
                        post_event(EV_DONE, '0, ERR_NONE);
                    default:
                        abort_parse(ERR_BAD_PREAMBLE);
                endcase
                mode_q = MODE_HALT;
            end
            else
            begin
                seen_any_q = 1'b1;
                case (mode_q)
                    MODE_WAIT:
                        if (!is_space(ch))
                        begin
                            if (ch == CH_C)
                                mode_q = MODE_COMMENT;
                            else if (ch == CH_P)
                                mode_q = MODE_PC;
                            else
                                abort_parse(ERR_NO_PREAMBLE);
                        end
                    MODE_COMMENT:
                        if (ch == CH_LF)
                            mode_q = MODE_WAIT;
                    MODE_PC, MODE_PN, MODE_PF:
                        if (!is_space(ch))
                        begin
                            if ((mode_q == MODE_PC && ch == CH_C) ||
                                (mode_q == MODE_PN && ch == CH_N) ||
                                (mode_q == MODE_PF && ch == CH_F))
                                mode_q = mode_q.next();
                            else
                                abort_parse(ERR_BAD_PREAMBLE);
                        end
                    MODE_VSTART, MODE_GAP:
                        if (!is_space(ch))
                        begin
                            if (!is_digit(ch))
                                abort_parse(ERR_BAD_PREAMBLE);
                            else if (mode_q == MODE_VSTART)
                                start_number(ch, MODE_VNUM);
                            else
                                start_number(ch, MODE_CNUM);
                        end
                    MODE_VNUM:
                        if (is_digit(ch))
                            accumulate_digit(ch);
                        else
                        begin
                            post_event(EV_VARS, {1'b0, magnitude_q}, ERR_NONE);
                            if (is_space(ch))
                                mode_q = MODE_GAP;
                            else
                                abort_parse(ERR_BAD_PREAMBLE);
                        end
                    MODE_CNUM:
                        if (is_digit(ch))
                            accumulate_digit(ch);
                        else
                        begin
                            post_event(EV_CLAUSES, {1'b0, magnitude_q}, ERR_NONE);
                            mode_q = MODE_CLAUSE;
                            clause_byte(ch, 1'b1);
                        end
                    MODE_CLAUSE:
                        clause_byte(ch, 1'b1);
                    MODE_SCOPE:
                        clause_byte(ch, 1'b0);
                    MODE_NEG:
                        if (is_digit(ch))
                            start_number(ch, MODE_LIT);
                        else
                            abort_parse(ERR_NEED_DIG);
                    MODE_LIT:
                        if (is_digit(ch))
                            accumulate_digit(ch);
                        else
                        begin
                            post_event(EV_LIT, literal_now(), ERR_NONE);
                            negative_q = 1'b0;
                            mode_q     = MODE_CLAUSE;
                            clause_byte(ch, 1'b1);
                        end
                    default:
                        mode_q = MODE_HALT;
                endcase
            end
            // Mark the final event of this item
            if (awaited_events.size() > count_before)
            begin
                tail = awaited_events.pop_back();
                tail.last = 1'b1;
                awaited_events.push_back(tail);
            end
        end
    endtask

    // Watch both channels: predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin : watch
        parse_event_t want;
        if (!rst_n)
        begin
            mode_q      = MODE_WAIT;
            magnitude_q = '0;
            negative_q  = 1'b0;
            seen_any_q  = 1'b0;
            awaited_events.delete();
            mismatches  = 0;
            checked     = 0;
            chars       = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                chars++;
                predict_item(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event: kind %0d value %0d code %0d last %0b",
                                 m_axis_tuser, $signed(m_axis_tdata[31:0]),
                                 m_axis_tdata[34:32], m_axis_tlast);
                end
                else
                begin
                    want = awaited_events.pop_front();
                    checked++;
                    if (m_axis_tuser !== want.kind || m_axis_tdata[31:0] !== want.value ||
                        m_axis_tdata[34:32] !== want.code || m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"event %0d: expected kind %0d value %0d code %0d ",
                                      "last %0b, got kind %0d value %0d code %0d last %0b"},
                                     checked, want.kind, $signed(want.value), want.code,
                                     want.last, m_axis_tuser, $signed(m_axis_tdata[31:0]),
                                     m_axis_tdata[34:32], m_axis_tlast);
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        events_pending <= awaited_events.size();
        events_checked <= checked;
        chars_seen     <= chars;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import qdp_pkg::*;

    localparam int NUMBER_BITS  = 32;
    localparam int ITEM_TARGET  = 1450;
    localparam int NOISE_ITEMS  = 24;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Ways the formula can close
    typedef enum int {
        END_LIT_EOF,
        END_CLAUSE_EOF,
        END_SCOPE_EOF,
        END_MINUS_EOF,
        END_MINUS_BAD,
        END_BAD_CHAR,
        END_OVERFLOW,
        END_DOUBLE_SCOPE
    } ending_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;
    int          mismatch_count;
    int          events_pending;
    int          events_checked;
    int          chars_seen;

    // Bit 8 is end_of_input, bits 7:0 the character
    logic [8:0]  char_stream[$];
    ending_e     ending;

    qdimacs_char_parser #(.NUMBER_BITS(NUMBER_BITS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    qdimacs_event_checker #(.NUMBER_BITS(NUMBER_BITS)) parse_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending),
        .events_checked (events_checked),
        .chars_seen     (chars_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random back-pressure on the event channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic add_char(input logic [7:0] ch);
        char_stream.push_back({1'b0, ch});
    endtask

    // End marker with a random, ignored character
    task automatic add_end_mark();
        logic [31:0] draw;
        draw = $urandom;
        char_stream.push_back({1'b1, draw[7:0]});
    endtask

    task automatic add_space();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 5)
            add_char(CH_SPACE);
        else
            add_char(CH_TAB + pick[7:0]);
    endtask

    task automatic add_decimal(input logic [31:0] magnitude);
        logic [7:0]  digits[$];
        logic [31:0] rest;
        logic [31:0] digit;
        rest = magnitude;
        do
        begin
            digit = rest % 10;
            digits.push_front(CH_ZERO + digit[7:0]);
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (digits[k])
            add_char(digits[k]);
    endtask

    // Literal with random sign, spread of sizes and occasional leading zeros
    task automatic add_literal(input logic force_minus);
        int          pick;
        int          lead_zeros;
        logic [31:0] mag;
        pick = $urandom_range(99);
        if (pick < 25)
            mag = 32'd0;
        else if (pick < 65)
            mag = $urandom_range(1, 99);
        else if (pick < 85)
            mag = $urandom_range(100, 99999);
        else if (pick < 93)
            mag = $urandom & 32'h7fff_ffff;
        else
            mag = 32'h7fff_ffff - $urandom_range(0, 9);
        if (force_minus || $urandom_range(2) == 0)
            add_char(CH_MINUS);
        lead_zeros = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lead_zeros)
            add_char(CH_ZERO);
        add_decimal(mag);
    endtask

    task automatic send_item(input logic [8:0] item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item[7:0];
        s_axis_tuser  <= item[8];
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic        after_scope;
        logic        glued;
        logic [31:0] draw;
        logic [7:0]  bad;
        int          main_len;

        // Leading blank and a comment carrying the byte extremes
        add_char(CH_SPACE);
        add_char(CH_C);
        add_char(8'hff);
        add_char(8'h00);
        add_char(8'h80);
        add_char(CH_LF);
        // Preamble with blanks between its letters
        add_char(CH_P);
        add_char(CH_SPACE);
        add_char(CH_C);
        add_char(CH_N);
        add_char(CH_CR);
        add_char(CH_F);
        add_char(CH_SPACE);
        add_decimal($urandom_range(0, 99));
        add_space();
        add_decimal($urandom_range(0, 999));
        // Clause count closed by a scope letter, literal closed by a minus
        add_char(CH_A);
        add_decimal(32'd1);
        add_char(CH_MINUS);
        add_decimal(32'h7fff_ffff);
        add_char(CH_SPACE);
        add_char(CH_E);
        add_char(CH_SPACE);
        add_decimal(32'd0);
        add_char(CH_LF);

        // Well-formed clause section with random content
        after_scope = 1'b0;
        glued       = 1'b0;
        while (char_stream.size() < ITEM_TARGET)
        begin
            if (!after_scope && $urandom_range(99) < 12)
            begin
                if ($urandom_range(1) == 1)
                    add_char(CH_A);
                else
                    add_char(CH_E);
                after_scope = 1'b1;
                glued       = 1'b0;
                repeat ($urandom_range(0, 2))
                    add_space();
            end
            else
            begin
                // A literal glued to the previous one must open with a minus
                add_literal(glued);
                after_scope = 1'b0;
                if ($urandom_range(7) == 0)
                    glued = 1'b1;
                else
                begin
                    glued = 1'b0;
                    repeat ($urandom_range(1, 3))
                        add_space();
                end
            end
        end

        // Settle in the clause section, then close the formula
        if (after_scope)
            add_literal(1'b0);
        add_space();
        ending = ending_e'($urandom_range(0, 7));
        case (ending)
            END_LIT_EOF:
            begin
                add_literal(1'b0);
                add_end_mark();
            end
            END_CLAUSE_EOF:
                add_end_mark();
            END_SCOPE_EOF:
            begin
                add_char(CH_E);
                add_space();
                add_end_mark();
            end
            END_MINUS_EOF:
            begin
                add_char(CH_MINUS);
                add_end_mark();
            end
            END_MINUS_BAD:
            begin
                do
                begin
                    draw = $urandom;
                    bad  = draw[7:0];
                end
                while (bad >= CH_ZERO && bad <= CH_NINE);
                add_char(CH_MINUS);
                add_char(bad);
            end
            END_BAD_CHAR:
            begin
                do
                begin
                    draw = $urandom;
                    bad  = draw[7:0];
                end
                while (bad == CH_SPACE || (bad >= CH_TAB && bad <= CH_CR) ||
                       (bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_MINUS ||
                       bad == CH_A || bad == CH_E);
                add_char(bad);
            end
            END_OVERFLOW:
                add_decimal(32'h8000_0000 + $urandom_range(0, 32'h7fff_ffff));
            default:
            begin
                add_char(CH_A);
                add_space();
                add_char(CH_E);
            end
        endcase
        main_len = char_stream.size();

        // Items after the stop, to be dropped
        repeat (NOISE_ITEMS)
        begin
            draw = $urandom;
            char_stream.push_back(draw[8:0]);
        end

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Three idling phases over the formula, none over the dropped tail
        send_idle_pct = 32;
        recv_stall_pct <= 65;
        foreach (char_stream[idx])
        begin
            if (idx == main_len / 3)
            begin
                send_idle_pct = 65;
                recv_stall_pct <= 32;
            end
            else if (idx == 2 * main_len / 3)
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            send_item(char_stream[idx]);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then hold a while to catch stray events
        repeat (2)
            @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Fed %0d characters, formula closed by %s, then %0d dropped items",
                 chars_seen, ending.name(), NOISE_ITEMS);
        $display("Checked %0d parse events, %0d mismatches, %0d still awaited",
                 events_checked, mismatch_count, events_pending);
        if (mismatch_count == 0 && events_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
